// ----- hw/rtl/gclf_pkg.sv -----
// gclf_pkg: types and constants shared by the g-code line framer
// no dependencies
package gclf_pkg;

  localparam int unsigned MaxDigits = 10;
  localparam int unsigned MaxLits   = 5;
  localparam int unsigned CfgWidth  = 30;

  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch1     = 8'h31;
  localparam logic [7:0] Ch4     = 8'h34;
  localparam logic [7:0] Ch9     = 8'h39;

  // held prefix of M109/M190 substitution
  localparam logic [1:0] MpNone = 2'd0;
  localparam logic [1:0] MpM    = 2'd1;
  localparam logic [1:0] MpM1   = 2'd2;
  localparam logic [1:0] MpM1x  = 2'd3;

  typedef enum logic [1:0] {
    PH_AWAIT,
    PH_KEPT,
    PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_N,
    BS_DIG,
    BS_SP,
    BS_LIT,
    BS_STAR,
    BS_XD,
    BS_NL
  } bstate_e;

  // one unit of output work handed from front to back
  typedef struct packed {
    logic                      hdr;
    logic                      trl;
    logic [4*MaxDigits-1:0]    bcd;
    logic [3:0]                top;
    logic [MaxLits-1:0][7:0]   lit;
    logic [2:0]                nlit;
    logic [7:0]                xr;
  } job_t;

endpackage

// ----- hw/rtl/gclf_front.sv -----
// gclf_front: classifies input bytes, tracks line state, builds jobs
// depends on gclf_pkg
module gclf_front #(
  parameter int unsigned LINE_DIGITS = 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  logic [7:0]                      byte_i,
  input  logic                            eod_i,
  input  logic                            cfg_we_i,
  input  logic [gclf_pkg::CfgWidth-1:0]   cfg_wdata_i,
  output logic                            push_o,
  output gclf_pkg::job_t                  job_o,
  output logic                            busy_o
);

  localparam int unsigned CW = 4 * LINE_DIGITS;
  localparam int unsigned BW = 4 * gclf_pkg::MaxDigits;

  gclf_pkg::phase_e phase_q, phase_d;
  logic       sp_q, sp_d, cmt_q, cmt_d, nine_q, nine_d;
  logic [1:0] mp_q, mp_d;
  logic [7:0] rx_q, rx_d;
  logic [CW-1:0] ctr_q, ctr_d;

  // binary to bcd load, one shift per cycle
  logic                          busy_q;
  logic [4:0]                    steps_q;
  logic [BW-1:0]                 conv_q, conv_adj, conv_nx;
  logic [gclf_pkg::CfgWidth-1:0] bin_q;

  always_comb begin
    conv_adj = conv_q;
    for (int i = 0; i < gclf_pkg::MaxDigits; i++) begin
      if (conv_q[4*i +: 4] >= 4'd5) conv_adj[4*i +: 4] = conv_q[4*i +: 4] + 4'd3;
    end
    conv_nx = {conv_adj[BW-2:0], bin_q[gclf_pkg::CfgWidth-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      steps_q <= '0;
    end else if (cfg_we_i) begin
      busy_q  <= 1'b1;
      steps_q <= 5'(gclf_pkg::CfgWidth);
    end else if (busy_q) begin
      steps_q <= steps_q - 5'd1;
      if (steps_q == 5'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_we_i) begin
      conv_q <= '0;
      bin_q  <= cfg_wdata_i;
    end else if (busy_q) begin
      conv_q <= conv_nx;
      bin_q  <= {bin_q[gclf_pkg::CfgWidth-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;

  // number prefix: highest nonzero digit and xor of its ascii digits
  logic [3:0] top;
  logic [7:0] numx;
  always_comb begin
    top  = '0;
    numx = '0;
    for (int i = 1; i < LINE_DIGITS; i++) begin
      if (ctr_q[4*i +: 4] != 4'd0) top = 4'(i);
    end
    for (int i = 0; i < LINE_DIGITS; i++) begin
      if (4'(i) <= top) numx = numx ^ (gclf_pkg::Ch0 | {4'd0, ctr_q[4*i +: 4]});
    end
  end

  // counter plus one, wraps past all nines
  logic [CW-1:0] ctr_inc;
  always_comb begin
    logic carry;
    carry   = 1'b1;
    ctr_inc = ctr_q;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      if (carry) begin
        ctr_inc[4*i +: 4] = (ctr_q[4*i +: 4] == 4'd9) ? 4'd0 : ctr_q[4*i +: 4] + 4'd1;
      end
      carry = carry && (ctr_q[4*i +: 4] == 4'd9);
    end
  end

  logic is_blank, eol, c_m;
  assign is_blank = (byte_i == gclf_pkg::ChSpace) || (byte_i == gclf_pkg::ChTab) ||
                    (byte_i == gclf_pkg::ChVt) || (byte_i == gclf_pkg::ChFf);
  assign eol = eod_i || (byte_i == gclf_pkg::ChLf);
  assign c_m = (byte_i == gclf_pkg::ChM);

  gclf_pkg::job_t job;
  always_comb begin
    logic [2:0] n;
    logic [7:0] x;
    logic       do_flush, do_match;
    n        = '0;
    x        = rx_q;
    do_flush = 1'b0;
    do_match = 1'b0;
    job      = '0;
    phase_d  = phase_q;
    sp_d     = sp_q;
    cmt_d    = cmt_q;
    mp_d     = mp_q;
    nine_d   = nine_q;
    rx_d     = rx_q;
    ctr_d    = ctr_q;

    if (eol) begin
      if (phase_q == gclf_pkg::PH_KEPT) begin
        do_flush = 1'b1;
        job.trl  = 1'b1;
        ctr_d    = ctr_inc;
      end
    end else if (byte_i == gclf_pkg::ChCr) begin
      // dropped
    end else if (phase_q == gclf_pkg::PH_AWAIT) begin
      if (byte_i == gclf_pkg::ChM || byte_i == gclf_pkg::ChG) begin
        job.hdr = 1'b1;
        x       = gclf_pkg::ChN ^ numx ^ gclf_pkg::ChSpace;
        phase_d = gclf_pkg::PH_KEPT;
        if (c_m) begin
          mp_d = gclf_pkg::MpM;
        end else begin
          job.lit[n] = byte_i; n = n + 3'd1; x = x ^ byte_i;
        end
      end else if (!is_blank) begin
        phase_d = gclf_pkg::PH_SKIP;
      end
    end else if (phase_q == gclf_pkg::PH_KEPT && !cmt_q) begin
      if (is_blank) begin
        do_flush = 1'b1;
        sp_d     = 1'b1;
      end else begin
        if (sp_q) begin
          job.lit[n] = gclf_pkg::ChSpace; n = n + 3'd1; x = x ^ gclf_pkg::ChSpace;
          sp_d = 1'b0;
        end
        if (byte_i == gclf_pkg::ChSemi) begin
          do_flush = 1'b1;
          cmt_d    = 1'b1;
        end else begin
          do_match = 1'b1;
        end
      end
    end

    if (do_match) begin
      if (mp_q == gclf_pkg::MpM && byte_i == gclf_pkg::Ch1) begin
        mp_d = gclf_pkg::MpM1;
      end else if (mp_q == gclf_pkg::MpM1 &&
                   (byte_i == gclf_pkg::Ch0 || byte_i == gclf_pkg::Ch9)) begin
        mp_d   = gclf_pkg::MpM1x;
        nine_d = (byte_i == gclf_pkg::Ch9);
      end else if (mp_q == gclf_pkg::MpM1x &&
                   ((!nine_q && byte_i == gclf_pkg::Ch9) ||
                    (nine_q && byte_i == gclf_pkg::Ch0))) begin
        // M109 -> M104, M190 -> M140
        job.lit[n] = gclf_pkg::ChM; n = n + 3'd1; x = x ^ gclf_pkg::ChM;
        job.lit[n] = gclf_pkg::Ch1; n = n + 3'd1; x = x ^ gclf_pkg::Ch1;
        job.lit[n] = nine_q ? gclf_pkg::Ch4 : gclf_pkg::Ch0; n = n + 3'd1;
        x = x ^ (nine_q ? gclf_pkg::Ch4 : gclf_pkg::Ch0);
        job.lit[n] = nine_q ? gclf_pkg::Ch0 : gclf_pkg::Ch4; n = n + 3'd1;
        x = x ^ (nine_q ? gclf_pkg::Ch0 : gclf_pkg::Ch4);
        mp_d   = gclf_pkg::MpNone;
        nine_d = 1'b0;
      end else begin
        do_flush = 1'b1;
      end
    end

    if (do_flush) begin
      if (mp_q != gclf_pkg::MpNone) begin
        job.lit[n] = gclf_pkg::ChM; n = n + 3'd1; x = x ^ gclf_pkg::ChM;
      end
      if (mp_q == gclf_pkg::MpM1 || mp_q == gclf_pkg::MpM1x) begin
        job.lit[n] = gclf_pkg::Ch1; n = n + 3'd1; x = x ^ gclf_pkg::Ch1;
      end
      if (mp_q == gclf_pkg::MpM1x) begin
        job.lit[n] = nine_q ? gclf_pkg::Ch9 : gclf_pkg::Ch0; n = n + 3'd1;
        x = x ^ (nine_q ? gclf_pkg::Ch9 : gclf_pkg::Ch0);
      end
      mp_d   = gclf_pkg::MpNone;
      nine_d = 1'b0;
      if (do_match) begin
        if (c_m) begin
          mp_d = gclf_pkg::MpM;
        end else begin
          job.lit[n] = byte_i; n = n + 3'd1; x = x ^ byte_i;
        end
      end
    end

    // a ten digit number fills the 12 word burst, the first line byte is not sent
    job.nlit = (job.hdr && top == 4'd9) ? 3'd0 : n;
    job.xr   = x;
    job.bcd  = BW'(ctr_q);
    job.top  = top;
    rx_d     = x;

    if (eol) begin
      phase_d = gclf_pkg::PH_AWAIT;
      sp_d    = 1'b0;
      cmt_d   = 1'b0;
      mp_d    = gclf_pkg::MpNone;
      nine_d  = 1'b0;
      rx_d    = '0;
    end
  end

  assign job_o  = job;
  assign push_o = acc_i && (job.hdr || job.trl || (job.nlit != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gclf_pkg::PH_AWAIT;
      sp_q    <= 1'b0;
      cmt_q   <= 1'b0;
      mp_q    <= gclf_pkg::MpNone;
      nine_q  <= 1'b0;
      rx_q    <= '0;
      ctr_q   <= '0;
    end else begin
      if (acc_i) begin
        phase_q <= phase_d;
        sp_q    <= sp_d;
        cmt_q   <= cmt_d;
        mp_q    <= mp_d;
        nine_q  <= nine_d;
        rx_q    <= rx_d;
      end
      if (busy_q && steps_q == 5'd1) begin
        ctr_q <= conv_nx[CW-1:0];
      end else if (acc_i) begin
        ctr_q <= ctr_d;
      end
    end
  end

endmodule

// ----- hw/rtl/gclf_fifo.sv -----
// gclf_fifo: short job queue between front and back
// depends on gclf_pkg
module gclf_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gclf_pkg::job_t data_i,
  input  logic           pop_i,
  output gclf_pkg::job_t data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gclf_pkg::job_t    mem_q [DEPTH];
  logic [AW-1:0]     wp_q, rp_q;
  logic [AW:0]       cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
      if (pop_i && !empty_o) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && !empty_o);
    end
  end

endmodule

// ----- hw/rtl/gclf_back.sv -----
// gclf_back: expands jobs into framed output words
// depends on gclf_pkg
module gclf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gclf_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [7:0]     byte_o,
  output logic           last_o
);

  gclf_pkg::bstate_e st_q, st_d;
  gclf_pkg::job_t    cur_q, cur_d;
  logic [3:0] dig_q, dig_d;
  logic [2:0] li_q, li_d;
  logic [1:0] xd_q, xd_d;
  logic       ov_q, ov_d, ol_q, ol_d;
  logic [7:0] ob_q, ob_d;

  // decimal digits of the checksum
  logic [1:0] hun;
  logic [6:0] rem;
  logic [3:0] ten, one;
  logic [14:0] prod;
  always_comb begin
    hun  = (cur_q.xr >= 8'd200) ? 2'd2 : (cur_q.xr >= 8'd100) ? 2'd1 : 2'd0;
    rem  = 7'(cur_q.xr - 8'(hun) * 8'd100);
    prod = 15'(rem) * 15'd205;
    ten  = 4'(prod >> 11);
    one  = 4'(rem - 7'(ten) * 7'd10);
  end

  function automatic gclf_pkg::bstate_e after_lits(input gclf_pkg::job_t j);
    return j.trl ? gclf_pkg::BS_STAR : gclf_pkg::BS_IDLE;
  endfunction

  logic adv;
  assign adv = !ov_q || ready_i;

  always_comb begin
    logic [7:0] b;
    b     = '0;
    st_d  = st_q;
    cur_d = cur_q;
    dig_d = dig_q;
    li_d  = li_q;
    xd_d  = xd_q;
    ov_d  = ov_q && !ready_i;
    ob_d  = ob_q;
    ol_d  = ol_q;
    pop_o = 1'b0;
    unique case (st_q)
      gclf_pkg::BS_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cur_d = job_i;
          dig_d = job_i.top;
          li_d  = '0;
          xd_d  = (job_i.xr >= 8'd100) ? 2'd0 : (job_i.xr >= 8'd10) ? 2'd1 : 2'd2;
          if (job_i.hdr)                 st_d = gclf_pkg::BS_N;
          else if (job_i.nlit != 3'd0)   st_d = gclf_pkg::BS_LIT;
          else                           st_d = after_lits(job_i);
        end
      end
      gclf_pkg::BS_N: begin
        b    = gclf_pkg::ChN;
        st_d = gclf_pkg::BS_DIG;
      end
      gclf_pkg::BS_DIG: begin
        b = gclf_pkg::Ch0 | {4'd0, cur_q.bcd[{dig_q, 2'b00} +: 4]};
        if (dig_q == 4'd0) st_d = gclf_pkg::BS_SP;
        else               dig_d = dig_q - 4'd1;
      end
      gclf_pkg::BS_SP: begin
        b    = gclf_pkg::ChSpace;
        st_d = (cur_q.nlit != 3'd0) ? gclf_pkg::BS_LIT : after_lits(cur_q);
      end
      gclf_pkg::BS_LIT: begin
        b = cur_q.lit[li_q];
        if (li_q + 3'd1 < cur_q.nlit) li_d = li_q + 3'd1;
        else                          st_d = after_lits(cur_q);
      end
      gclf_pkg::BS_STAR: begin
        b    = gclf_pkg::ChStar;
        st_d = gclf_pkg::BS_XD;
      end
      gclf_pkg::BS_XD: begin
        unique case (xd_q)
          2'd0:    b = gclf_pkg::Ch0 | {6'd0, hun};
          2'd1:    b = gclf_pkg::Ch0 | {4'd0, ten};
          default: b = gclf_pkg::Ch0 | {4'd0, one};
        endcase
        if (xd_q >= 2'd2) st_d = gclf_pkg::BS_NL;
        else              xd_d = xd_q + 2'd1;
      end
      gclf_pkg::BS_NL: begin
        b    = gclf_pkg::ChLf;
        st_d = gclf_pkg::BS_IDLE;
      end
      default: st_d = gclf_pkg::BS_IDLE;
    endcase
    // emitting states only move when the output register is free
    if (st_q != gclf_pkg::BS_IDLE) begin
      if (adv) begin
        ov_d = 1'b1;
        ob_d = b;
        ol_d = (st_d == gclf_pkg::BS_IDLE);
      end else begin
        st_d  = st_q;
        dig_d = dig_q;
        li_d  = li_q;
        xd_d  = xd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= gclf_pkg::BS_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    dig_q <= dig_d;
    li_q  <= li_d;
    xd_q  <= xd_d;
    ob_q  <= ob_d;
    ol_q  <= ol_d;
  end

  assign valid_o = ov_q;
  assign byte_o  = ob_q;
  assign last_o  = ol_q;

endmodule

// ----- hw/rtl/gcode_line_number_checksum_framer_unit.sv -----
// gcode_line_number_checksum_framer_unit: top level of the g-code line framer
// depends on gclf_pkg, gclf_front, gclf_fifo, gclf_back
//
// channel   dir  contents
// s_axis    in   tdata = data_byte, tuser = end_of_data
// m_axis    out  tdata = out_byte, tlast = last_of_run
// cfg       in   cfg_wdata_i = start_line_number
//
// a byte is taken each cycle while the job queue has room and no counter
// load runs; the back end sends one word per cycle while the output is not
// stalled, after loading each job in its idle state, up to 12 words for a line start and 8 for a line end.
// a start value write runs a binary to bcd load, input held off.
// reset clears line state and sets the line counter to zero.
module gcode_line_number_checksum_framer_unit #(
  parameter int unsigned LINE_DIGITS = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tuser,   // [0] end_of_data
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [gclf_pkg::CfgWidth-1:0] cfg_wdata_i
);

  logic           acc, push, pop, full, empty, busy;
  gclf_pkg::job_t job_in, job_out;

  assign s_axis_tready = !busy && !full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  gclf_front #(.LINE_DIGITS(LINE_DIGITS)) u_front (
    .clk_i, .rst_ni,
    .acc_i       (acc),
    .byte_i      (s_axis_tdata),
    .eod_i       (s_axis_tuser),
    .cfg_we_i,
    .cfg_wdata_i,
    .push_o      (push),
    .job_o       (job_in),
    .busy_o      (busy)
  );

  gclf_fifo #(.DEPTH(4)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  gclf_back u_back (
    .clk_i, .rst_ni,
    .job_i   (job_out),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("input taken during counter load");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full)) else $error("job queue overflow");

  a_load_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(cfg_we_i)) else $error("counter load without write");

endmodule
